/* design/ucs_pkg.sv */
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types and character codes for the URL component splitter.
// ----------------------------------------------------------------------------
package ucs_pkg;

    // Width of every result field on the ports.
    localparam int OUT_W = 11;

    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_QUESTION = 8'h3F;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_AFTER,
        PH_HOST,
        PH_PATH
    } t_phase;

endpackage

/* design/url_component_splitter.sv */
// ----------------------------------------------------------------------------
// url_component_splitter
// Splits a URL that arrives one character per item into the offsets and
// lengths of user, password, host, port, path and query.
// ----------------------------------------------------------------------------
// Result: registered; it appears in the cycle after the terminating zero is taken.
// Throughput: one character per cycle; the parse state and the result
// register are updated in the same cycle, so ready only drops while a
// result is held and the output side stalls.
// Reset: synchronous, active low; clears the parse state and the result valid.
module url_component_splitter #(
    parameter int MAX_LEN = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_ch,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ucs_pkg::OUT_W-1:0] o_user_pos,
    output logic [ucs_pkg::OUT_W-1:0] o_user_len,
    output logic [ucs_pkg::OUT_W-1:0] o_password_pos,
    output logic [ucs_pkg::OUT_W-1:0] o_password_len,
    output logic [ucs_pkg::OUT_W-1:0] o_host_pos,
    output logic [ucs_pkg::OUT_W-1:0] o_host_len,
    output logic [ucs_pkg::OUT_W-1:0] o_port_pos,
    output logic [ucs_pkg::OUT_W-1:0] o_port_len,
    output logic [ucs_pkg::OUT_W-1:0] o_path_start,
    output logic [ucs_pkg::OUT_W-1:0] o_path_size,
    output logic [ucs_pkg::OUT_W-1:0] o_query_pos,
    output logic [ucs_pkg::OUT_W-1:0] o_query_len
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

    function automatic logic [PW-1:0] span(input logic [PW-1:0] e, input logic [PW-1:0] s);
        return (e > s) ? e - s : '0;
    endfunction

    function automatic logic [PW-1:0] sat_next(input logic [PW-1:0] x);
        return (x < MAX_POS) ? x + PW'(1) : MAX_POS;
    endfunction

    function automatic logic [ucs_pkg::OUT_W-1:0] to_out(input logic [PW-1:0] x);
        return ucs_pkg::OUT_W'(32'(x));
    endfunction

    // Parse state.
    ucs_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_prev, n_prev;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_qpos, n_qpos;
    logic            r_qseen, n_qseen;
    logic [PW-1:0]   r_upos, n_upos, r_ulen, n_ulen;
    logic [PW-1:0]   r_wpos, n_wpos, r_wlen, n_wlen;
    logic [PW-1:0]   r_hpos, n_hpos, r_hlen, n_hlen;
    logic [PW-1:0]   r_ppos, n_ppos, r_plen, n_plen;
    logic [PW-1:0]   r_tpos, n_tpos;

    // Result register.
    logic            r_out_valid;
    logic [PW-1:0]   r_res [12];
    logic [PW-1:0]   n_res [12];

    logic            in_acc;
    logic            host_phase;
    logic [PW-1:0]   hp_eff;
    logic [PW-1:0]   cl_hlen, cl_plen;
    logic [PW-1:0]   end_tpos, end_qpos, path_end;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // Host part either already open or opened by this character.
    assign host_phase = (r_phase == ucs_pkg::PH_HOST) || (r_phase == ucs_pkg::PH_AFTER);
    assign hp_eff     = (r_phase == ucs_pkg::PH_AFTER) ? r_pos : r_hpos;

    // Closing the open part: the port once a host length exists, else the host.
    assign cl_hlen = (r_hlen != '0) ? r_hlen : span(r_pos, hp_eff);
    assign cl_plen = (r_hlen != '0) ? span(r_pos, r_ppos) : r_plen;

    always_comb begin
        end_tpos = r_tpos;
        case (r_phase)
            ucs_pkg::PH_AFTER,
            ucs_pkg::PH_HOST:   end_tpos = r_pos;
            ucs_pkg::PH_SEARCH: end_tpos = '0;
            default:            end_tpos = r_tpos;
        endcase
    end

    assign path_end = r_qseen ? r_qpos : r_pos;
    assign end_qpos = r_qseen ? sat_next(r_qpos) : '0;

    always_comb begin
        n_phase = r_phase;
        n_prev  = {r_prev[7:0], i_ch};
        n_pos   = sat_next(r_pos);
        n_qpos  = r_qpos;
        n_qseen = r_qseen;
        n_upos  = r_upos;
        n_ulen  = r_ulen;
        n_wpos  = r_wpos;
        n_wlen  = r_wlen;
        n_hpos  = r_hpos;
        n_hlen  = r_hlen;
        n_ppos  = r_ppos;
        n_plen  = r_plen;
        n_tpos  = r_tpos;

        n_res[0]  = r_upos;
        n_res[1]  = r_ulen;
        n_res[2]  = r_wpos;
        n_res[3]  = r_wlen;
        n_res[4]  = host_phase ? hp_eff : r_hpos;
        n_res[5]  = host_phase ? cl_hlen : r_hlen;
        n_res[6]  = r_ppos;
        n_res[7]  = host_phase ? cl_plen : r_plen;
        n_res[8]  = end_tpos;
        n_res[9]  = span(path_end, end_tpos);
        n_res[10] = end_qpos;
        n_res[11] = r_qseen ? span(r_pos, end_qpos) : '0;

        if (i_ch == ucs_pkg::CH_END) begin
            // The URL is complete: clear everything for the next one.
            n_phase = ucs_pkg::PH_SEARCH;
            n_prev  = '0;
            n_pos   = '0;
            n_qpos  = '0;
            n_qseen = 1'b0;
            n_upos  = '0;
            n_ulen  = '0;
            n_wpos  = '0;
            n_wlen  = '0;
            n_hpos  = '0;
            n_hlen  = '0;
            n_ppos  = '0;
            n_plen  = '0;
            n_tpos  = '0;
        end else begin
            case (r_phase)
                ucs_pkg::PH_SEARCH: begin
                    if (i_ch == ucs_pkg::CH_QUESTION && !r_qseen) begin
                        n_qpos  = r_pos;
                        n_qseen = 1'b1;
                    end
                    if (r_prev == {ucs_pkg::CH_COLON, ucs_pkg::CH_SLASH} &&
                        i_ch == ucs_pkg::CH_SLASH) begin
                        // A question mark before the scheme mark is forgotten.
                        n_qpos  = '0;
                        n_qseen = 1'b0;
                        n_phase = ucs_pkg::PH_AFTER;
                    end
                end
                ucs_pkg::PH_AFTER,
                ucs_pkg::PH_HOST: begin
                    if (r_phase == ucs_pkg::PH_AFTER) begin
                        n_hpos  = r_pos;
                        n_phase = ucs_pkg::PH_HOST;
                    end
                    if (r_phase == ucs_pkg::PH_AFTER && i_ch == ucs_pkg::CH_SLASH) begin
                        // A slash right after the scheme mark: no host part.
                        n_hpos  = r_hpos;
                        n_tpos  = r_pos;
                        n_phase = ucs_pkg::PH_PATH;
                    end else if (i_ch == ucs_pkg::CH_COLON) begin
                        n_hlen = span(r_pos, hp_eff);
                        n_ppos = sat_next(r_pos);
                    end else if (i_ch == ucs_pkg::CH_SLASH) begin
                        n_hlen  = cl_hlen;
                        n_plen  = cl_plen;
                        n_tpos  = r_pos;
                        n_phase = ucs_pkg::PH_PATH;
                    end else if (i_ch == ucs_pkg::CH_AT) begin
                        // What was read as host and port becomes user and password.
                        n_upos = hp_eff;
                        n_ulen = cl_hlen;
                        n_wpos = r_ppos;
                        n_wlen = cl_plen;
                        n_hpos = sat_next(r_pos);
                        n_hlen = '0;
                        n_ppos = '0;
                        n_plen = '0;
                    end
                end
                default: begin
                    if (i_ch == ucs_pkg::CH_QUESTION && !r_qseen) begin
                        n_qpos  = r_pos;
                        n_qseen = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ucs_pkg::PH_SEARCH;
            r_prev      <= '0;
            r_pos       <= '0;
            r_qpos      <= '0;
            r_qseen     <= 1'b0;
            r_upos      <= '0;
            r_ulen      <= '0;
            r_wpos      <= '0;
            r_wlen      <= '0;
            r_hpos      <= '0;
            r_hlen      <= '0;
            r_ppos      <= '0;
            r_plen      <= '0;
            r_tpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_prev  <= n_prev;
                r_pos   <= n_pos;
                r_qpos  <= n_qpos;
                r_qseen <= n_qseen;
                r_upos  <= n_upos;
                r_ulen  <= n_ulen;
                r_wpos  <= n_wpos;
                r_wlen  <= n_wlen;
                r_hpos  <= n_hpos;
                r_hlen  <= n_hlen;
                r_ppos  <= n_ppos;
                r_plen  <= n_plen;
                r_tpos  <= n_tpos;
            end
            if (in_acc && i_ch == ucs_pkg::CH_END) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_ch == ucs_pkg::CH_END) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_user_pos     = to_out(r_res[0]);
    assign o_user_len     = to_out(r_res[1]);
    assign o_password_pos = to_out(r_res[2]);
    assign o_password_len = to_out(r_res[3]);
    assign o_host_pos     = to_out(r_res[4]);
    assign o_host_len     = to_out(r_res[5]);
    assign o_port_pos     = to_out(r_res[6]);
    assign o_port_len     = to_out(r_res[7]);
    assign o_path_start   = to_out(r_res[8]);
    assign o_path_size    = to_out(r_res[9]);
    assign o_query_pos    = to_out(r_res[10]);
    assign o_query_len    = to_out(r_res[11]);

endmodule

/* design/ucs_checker.sv */
// ----------------------------------------------------------------------------
// ucs_checker
// Port-level checks for the URL component splitter, bound to the top level.
// ----------------------------------------------------------------------------
module ucs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [7:0]                i_ch,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [ucs_pkg::OUT_W-1:0] o_user_pos,
    input logic [ucs_pkg::OUT_W-1:0] o_user_len,
    input logic [ucs_pkg::OUT_W-1:0] o_password_pos,
    input logic [ucs_pkg::OUT_W-1:0] o_password_len,
    input logic [ucs_pkg::OUT_W-1:0] o_host_pos,
    input logic [ucs_pkg::OUT_W-1:0] o_host_len,
    input logic [ucs_pkg::OUT_W-1:0] o_port_pos,
    input logic [ucs_pkg::OUT_W-1:0] o_port_len,
    input logic [ucs_pkg::OUT_W-1:0] o_path_start,
    input logic [ucs_pkg::OUT_W-1:0] o_path_size,
    input logic [ucs_pkg::OUT_W-1:0] o_query_pos,
    input logic [ucs_pkg::OUT_W-1:0] o_query_len
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_host_pos) &&
        $stable(o_path_start) && $stable(o_query_len) && $stable(o_user_len))
        else $error("stalled result changed");

    // The terminator always produces a result in the next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_ch == ucs_pkg::CH_END |=> o_out_valid)
        else $error("terminator gave no result");

    // Other characters never produce a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_ch != ucs_pkg::CH_END && (!o_out_valid || i_out_ready)
        |=> !o_out_valid)
        else $error("result without terminator");

    // With no result waiting, the input side is never stalled.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output empty");

endmodule

bind url_component_splitter ucs_checker u_ucs_checker (.*);

/* tb/url_component_splitter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_component_splitter_test
// Feeds URLs one character per item into the splitter and checks every
// result against a parser written here that tracks the same state: scheme
// mark search, host and port parts with their overwrite rules, path and query
// split, and saturation of long URLs. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module url_component_splitter_test;

    localparam int          N_FIELDS     = 12;
    localparam int unsigned MAX_LEN      = 1024;
    localparam int          F_UPOS       = 0;
    localparam int          F_ULEN       = 1;
    localparam int          F_WPOS       = 2;
    localparam int          F_WLEN       = 3;
    localparam int          F_HPOS       = 4;
    localparam int          F_HLEN       = 5;
    localparam int          F_PPOS       = 6;
    localparam int          F_PLEN       = 7;
    localparam int          F_TPOS       = 8;
    localparam int          F_TLEN       = 9;
    localparam int          F_QPOS       = 10;
    localparam int          F_QLEN       = 11;
    localparam int          SHORT_ITEMS  = 1200;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_CYCLES = 600000;
    localparam logic [7:0]  CH_A         = 8'h61;
    localparam logic [7:0]  CH_ZERO      = 8'h30;

    typedef logic [N_FIELDS-1:0][ucs_pkg::OUT_W-1:0] t_layout;

    typedef struct {
        logic [7:0] ch;
        int         gap;
        bit         drain;
    } t_char_item;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    logic [7:0]     i_ch = ucs_pkg::CH_END;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    logic [ucs_pkg::OUT_W-1:0] o_user_pos, o_user_len, o_password_pos, o_password_len;
    logic [ucs_pkg::OUT_W-1:0] o_host_pos, o_host_len, o_port_pos, o_port_len;
    logic [ucs_pkg::OUT_W-1:0] o_path_start, o_path_size, o_query_pos, o_query_len;

    url_component_splitter #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_ch           (i_ch),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_user_pos     (o_user_pos),
        .o_user_len     (o_user_len),
        .o_password_pos (o_password_pos),
        .o_password_len (o_password_len),
        .o_host_pos     (o_host_pos),
        .o_host_len     (o_host_len),
        .o_port_pos     (o_port_pos),
        .o_port_len     (o_port_len),
        .o_path_start   (o_path_start),
        .o_path_size    (o_path_size),
        .o_query_pos    (o_query_pos),
        .o_query_len    (o_query_len)
    );

    string field_name [N_FIELDS] = '{"user_pos", "user_len", "password_pos",
        "password_len", "host_pos", "host_len", "port_pos", "port_len",
        "path_start", "path_size", "query_pos", "query_len"};

    t_char_item char_q [$];
    t_layout    layout_q [$];
    int         n_queued;
    int         n_short;
    int         n_urls;
    int         chars_taken;
    int         results_seen;
    int         n_errors;
    int         cycles;
    bit         drain_next;

    // Parser state kept alongside the block.
    ucs_pkg::t_phase prs_phase;
    logic [15:0]     prs_last2;
    int unsigned     prs_pos;
    int unsigned     prs_qpos;
    bit              prs_qseen;
    int unsigned     prs_part [N_FIELDS];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned sat_inc(input int unsigned x);
        return (x < MAX_LEN) ? x + 1 : MAX_LEN;
    endfunction

    function automatic int unsigned clip_len(input int unsigned stop, input int unsigned start);
        return (stop > start) ? stop - start : 0;
    endfunction

    task clear_parse();
        prs_phase = ucs_pkg::PH_SEARCH;
        prs_last2 = '0;
        prs_pos   = 0;
        prs_qpos  = 0;
        prs_qseen = 1'b0;
        foreach (prs_part[k]) prs_part[k] = 0;
    endtask

    // Closes whichever of host or port is still open.
    task close_segment(input int unsigned at);
        if (prs_part[F_HLEN] > 0)
            prs_part[F_PLEN] = clip_len(at, prs_part[F_PPOS]);
        else
            prs_part[F_HLEN] = clip_len(at, prs_part[F_HPOS]);
    endtask

    task host_step(input int unsigned at, input logic [7:0] c);
        case (c)
            ucs_pkg::CH_COLON: begin
                prs_part[F_HLEN] = clip_len(at, prs_part[F_HPOS]);
                prs_part[F_PPOS] = sat_inc(at);
            end
            ucs_pkg::CH_SLASH: begin
                close_segment(at);
                prs_part[F_TPOS] = at;
                prs_phase = ucs_pkg::PH_PATH;
            end
            ucs_pkg::CH_AT: begin
                // What was parsed as host and port was really user info.
                close_segment(at);
                prs_part[F_UPOS] = prs_part[F_HPOS];
                prs_part[F_ULEN] = prs_part[F_HLEN];
                prs_part[F_WPOS] = prs_part[F_PPOS];
                prs_part[F_WLEN] = prs_part[F_PLEN];
                prs_part[F_HPOS] = sat_inc(at);
                prs_part[F_HLEN] = 0;
                prs_part[F_PPOS] = 0;
                prs_part[F_PLEN] = 0;
            end
            default: ;
        endcase
    endtask

    task split_char(input logic [7:0] c);
        t_layout     want;
        int unsigned at;
        int unsigned stop;
        at = prs_pos;
        if (c == ucs_pkg::CH_END) begin
            if (prs_phase == ucs_pkg::PH_AFTER) begin
                prs_part[F_HPOS] = at;
                prs_phase = ucs_pkg::PH_HOST;
            end
            if (prs_phase == ucs_pkg::PH_HOST) begin
                close_segment(at);
                prs_part[F_TPOS] = at;
            end else if (prs_phase == ucs_pkg::PH_SEARCH) begin
                prs_part[F_TPOS] = 0;
            end
            stop = prs_qseen ? prs_qpos : at;
            prs_part[F_TLEN] = clip_len(stop, prs_part[F_TPOS]);
            if (prs_qseen) begin
                prs_part[F_QPOS] = sat_inc(prs_qpos);
                prs_part[F_QLEN] = clip_len(at, prs_part[F_QPOS]);
            end
            for (int k = 0; k < N_FIELDS; k++) want[k] = prs_part[k][ucs_pkg::OUT_W-1:0];
            layout_q.push_back(want);
            clear_parse();
        end else begin
            case (prs_phase)
                ucs_pkg::PH_SEARCH: begin
                    if (c == ucs_pkg::CH_QUESTION && !prs_qseen) begin
                        prs_qpos  = at;
                        prs_qseen = 1'b1;
                    end
                    // A question mark seen before the scheme mark does not count.
                    if (prs_last2 == {ucs_pkg::CH_COLON, ucs_pkg::CH_SLASH} &&
                        c == ucs_pkg::CH_SLASH) begin
                        prs_qseen = 1'b0;
                        prs_qpos  = 0;
                        prs_phase = ucs_pkg::PH_AFTER;
                    end
                end
                ucs_pkg::PH_AFTER: begin
                    if (c == ucs_pkg::CH_SLASH) begin
                        prs_part[F_TPOS] = at;
                        prs_phase = ucs_pkg::PH_PATH;
                    end else begin
                        prs_part[F_HPOS] = at;
                        prs_phase = ucs_pkg::PH_HOST;
                        host_step(at, c);
                    end
                end
                ucs_pkg::PH_HOST: host_step(at, c);
                default: begin
                    if (c == ucs_pkg::CH_QUESTION && !prs_qseen) begin
                        prs_qpos  = at;
                        prs_qseen = 1'b1;
                    end
                end
            endcase
            prs_last2 = {prs_last2[7:0], c};
            prs_pos = sat_inc(prs_pos);
        end
    endtask

    task check_layout(input t_layout got);
        t_layout want;
        if (layout_q.size() == 0) begin
            $display("%0t: result with no URL pending, actual %h", $time, got);
            n_errors++;
        end else begin
            want = layout_q.pop_front();
            for (int k = 0; k < N_FIELDS; k++) begin
                if (got[k] !== want[k]) begin
                    $display("%0t: %s expected %0d actual %0d",
                             $time, field_name[k], want[k], got[k]);
                    n_errors++;
                end
            end
        end
    endtask

    // Every third stretch of 200 characters goes without idle cycles.
    task add_ch(input logic [7:0] c);
        t_char_item it;
        it.ch    = c;
        it.gap   = ((n_queued / 200) % 3 == 2) ? 0 : $urandom_range(0, 19);
        it.drain = drain_next;
        drain_next = 1'b0;
        char_q.push_back(it);
        n_queued++;
    endtask

    task add_text(input string s);
        for (int k = 0; k < s.len(); k++) add_ch(s[k]);
    endtask

    task add_word(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 35);
            add_ch((r < 26) ? CH_A + 8'(r) : CH_ZERO + 8'(r - 26));
        end
    endtask

    // Two long URLs push offsets past the saturation point.
    task add_long(input bit with_scheme);
        if (with_scheme) begin
            add_text("s://u:p@");
            add_word(700);
            add_ch(ucs_pkg::CH_COLON);
            add_word(400);
            add_text(":9/");
            add_word(20);
            add_ch(ucs_pkg::CH_QUESTION);
            add_word(10);
        end else begin
            add_word(500);
            add_ch(ucs_pkg::CH_QUESTION);
            add_word(530);
        end
        add_ch(ucs_pkg::CH_END);
    endtask

    task add_url();
        logic [7:0] tricky [6];
        int         kind;
        int         start;
        tricky = '{ucs_pkg::CH_COLON, ucs_pkg::CH_SLASH, ucs_pkg::CH_AT,
                   ucs_pkg::CH_QUESTION, CH_A, CH_ZERO};
        start = n_queued;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            if ($urandom_range(0, 7) == 0) begin
                add_word($urandom_range(0, 2));
                add_ch(ucs_pkg::CH_QUESTION);
            end
            add_word($urandom_range(0, 4));
            add_text("://");
            if ($urandom_range(0, 5) == 0) begin
                add_ch(ucs_pkg::CH_SLASH);
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    add_word($urandom_range(0, 4));
                    if ($urandom_range(0, 1)) begin
                        add_ch(ucs_pkg::CH_COLON);
                        add_word($urandom_range(0, 4));
                    end
                    add_ch(ucs_pkg::CH_AT);
                end
                add_word($urandom_range(0, 6));
                repeat ($urandom_range(0, 2)) begin
                    add_ch(ucs_pkg::CH_COLON);
                    add_word($urandom_range(0, 4));
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 3)) begin
                    add_ch(ucs_pkg::CH_SLASH);
                    add_word($urandom_range(0, 4));
                    if ($urandom_range(0, 5) == 0) add_ch(tricky[$urandom_range(0, 2)]);
                end
            end
            if ($urandom_range(0, 1)) begin
                add_ch(ucs_pkg::CH_QUESTION);
                add_word($urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0) add_ch(tricky[$urandom_range(0, 3)]);
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(0, 12)) add_ch(tricky[$urandom_range(0, 5)]);
        end else begin
            repeat ($urandom_range(0, 10)) add_ch(8'($urandom_range(1, 255)));
        end
        add_ch(ucs_pkg::CH_END);
        n_short += n_queued - start;
    endtask

    // Sender: takes the next character once its idle count has run out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                split_char(i_ch);
                chars_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (char_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (char_q[0].gap > 0) begin
                    char_q[0].gap--;
                    i_in_valid <= 1'b0;
                end else if (char_q[0].drain && layout_q.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_ch <= char_q[0].ch;
                    void'(char_q.pop_front());
                end
            end
        end
    end

    int stall_left;
    int hold_left;

    // Receiver: stalls at random after most results, with a long hold-off after the 10th and 50th.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_layout({o_query_len, o_query_pos, o_path_size, o_path_start,
                              o_port_len, o_port_pos, o_host_len, o_host_pos,
                              o_password_len, o_password_pos, o_user_len, o_user_pos});
                results_seen++;
                stall_left = (results_seen % 16 >= 12) ? 0 : $urandom_range(0, 19);
                if (results_seen == 10 || results_seen == 50) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results pending", $time, layout_q.size());
            $display("url_component_splitter_test NOT OK");
            $finish;
        end
    end

    initial begin
        clear_parse();

        // Directed: empty URL, end right after the scheme mark, and a URL with
        // a question mark ahead of the scheme, user info, repeated port colons
        // and an all-ones byte in the query.
        add_ch(ucs_pkg::CH_END);
        n_urls++;
        add_text("x://");
        add_ch(ucs_pkg::CH_END);
        n_urls++;
        add_text("?s://a:b@h:9:8/p?q");
        add_ch(8'hFF);
        add_ch(ucs_pkg::CH_END);
        n_urls++;

        while (n_short < SHORT_ITEMS) begin
            if (n_urls == 30 || n_urls == 70) drain_next = 1'b1;
            if (n_urls == 5) add_long(1'b1);
            else if (n_urls == 25) add_long(1'b0);
            else add_url();
            n_urls++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken != n_queued) @(posedge i_clk);
        while (layout_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters in %0d URLs, including two past the length limit;",
                 n_queued, n_urls);
        $display("checked %0d results, %0d field mismatches.", results_seen, n_errors);
        if (n_errors == 0) begin
            $display("url_component_splitter_test OK");
        end else begin
            $display("url_component_splitter_test NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
design/ucs_pkg.sv
design/url_component_splitter.sv
design/ucs_checker.sv
tb/url_component_splitter_test.sv
